// ===== sv/vtwm_pkg.sv =====
// ----------------------------------------------------------------------------
// vtwm_pkg
// Types and constants shared by the wipe / iris / dissolve mixer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package vtwm_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_AMOUNT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SEED   = 3'd4;

  localparam int MODE_W     = 2;
  localparam int AMOUNT_W   = 17;
  localparam int SIZE_CFG_W = 13;
  localparam int SEED_W     = 32;
  localparam int PIXEL_W    = 32;

  // transition modes
  localparam logic [MODE_W-1:0] MODE_RECT     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CIRCLE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DISSOLVE = 2'd2;

  localparam logic [AMOUNT_W-1:0]   Q16_ONE      = 17'h10000;
  localparam logic [SIZE_CFG_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [SIZE_CFG_W-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [SEED_W-1:0]     SEED_RESET   = 32'h91FD57B4;
  localparam logic [SEED_W-1:0]     LCG_ADD      = 32'd32749;

  // circle compare: distance squared is scaled by 4 * 2^32
  localparam int CIRCLE_SHIFT = 34;

  // cycles the geometry pipeline needs after a write before items may enter
  localparam logic [1:0] SETTLE_CYCLES = 2'd2;

  typedef struct packed {
    logic [PIXEL_W-1:0] first_pixel;
    logic [PIXEL_W-1:0] second_pixel;
  } pixel_in_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] mixed_pixel;
    logic               took_second;
    logic               frame_end;
  } pixel_out_t;

endpackage

`default_nettype wire

// ===== sv/vtwm_setup.sv =====
// ----------------------------------------------------------------------------
// vtwm_setup
// Configuration registers and the short pipeline that turns them into the
// per-frame geometry used by the pixel path (borders, center, radius term).
// ----------------------------------------------------------------------------
`default_nettype none

module vtwm_setup
  import vtwm_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  localparam int CW  = $clog2(MAX_WIDTH),
  localparam int RC  = $clog2(MAX_HEIGHT),
  localparam int WW  = $clog2(MAX_WIDTH + 1),
  localparam int HW  = $clog2(MAX_HEIGHT + 1),
  localparam int SW  = (WW > HW) ? WW : HW,
  localparam int SZ  = 2 * SW + 1,
  localparam int RHS_W = 32 + SZ
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output logic                        busy,
  output logic [MODE_W-1:0]           mode,
  output logic [SEED_W-1:0]           seed,
  output logic [AMOUNT_W-1:0]         a_sat,
  output logic [CW-1:0]               w_last,
  output logic [RC-1:0]               h_last,
  output logic [CW-1:0]               cx,
  output logic [RC-1:0]               cy,
  output logic [WW-1:0]               xb,
  output logic [HW-1:0]               yb,
  output logic [WW-1:0]               x_hi,
  output logic [HW-1:0]               y_hi,
  output logic [RHS_W-1:0]            rhs
);

  localparam int WEXT = (WW > SIZE_CFG_W) ? WW : SIZE_CFG_W;
  localparam int HEXT = (HW > SIZE_CFG_W) ? HW : SIZE_CFG_W;

  logic [AMOUNT_W-1:0]   amount;
  logic [SIZE_CFG_W-1:0] frame_width;
  logic [SIZE_CFG_W-1:0] frame_height;
  logic [1:0]            settle;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_RECT;
      amount       <= '0;
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
      seed         <= SEED_RESET;
      settle       <= SETTLE_CYCLES;
    end else if (cfg_write) begin
      settle <= SETTLE_CYCLES;
      case (cfg_index)
        REG_MODE:   mode         <= cfg_data[MODE_W-1:0];
        REG_AMOUNT: amount       <= cfg_data[AMOUNT_W-1:0];
        REG_WIDTH:  frame_width  <= cfg_data[SIZE_CFG_W-1:0];
        REG_HEIGHT: frame_height <= cfg_data[SIZE_CFG_W-1:0];
        REG_SEED:   seed         <= cfg_data[SEED_W-1:0];
        default: ;
      endcase
    end else if (settle != 2'd0) begin
      settle <= settle - 2'd1;
    end
  end

  assign busy = (settle != 2'd0);

  // ---- stage 1: clamp sizes and amount, first products
  logic [WEXT-1:0]     fw_ext;
  logic [HEXT-1:0]     fh_ext;
  logic [WW-1:0]       w_eff_next;
  logic [HW-1:0]       h_eff_next;
  logic [AMOUNT_W-1:0] a_sat_next;
  logic [AMOUNT_W-1:0] inv_next;

  always_comb begin
    fw_ext = WEXT'(frame_width);
    fh_ext = HEXT'(frame_height);
    if (frame_width == '0) begin
      w_eff_next = WW'(1);
    end else if (fw_ext > WEXT'(MAX_WIDTH)) begin
      w_eff_next = WW'(MAX_WIDTH);
    end else begin
      w_eff_next = WW'(fw_ext);
    end
    if (frame_height == '0) begin
      h_eff_next = HW'(1);
    end else if (fh_ext > HEXT'(MAX_HEIGHT)) begin
      h_eff_next = HW'(MAX_HEIGHT);
    end else begin
      h_eff_next = HW'(fh_ext);
    end
    a_sat_next = (amount > Q16_ONE) ? Q16_ONE : amount;
    inv_next   = Q16_ONE - a_sat_next;
  end

  logic [WW-1:0]       w_eff;
  logic [HW-1:0]       h_eff;
  logic [31:0]         a_sq;
  logic                a_full;
  logic [2*WW-1:0]     w_sq;
  logic [2*HW-1:0]     h_sq;
  logic [WW+16:0]      w_inv;
  logic [HW+16:0]      h_inv;

  always_ff @(posedge clk) begin
    w_eff  <= w_eff_next;
    h_eff  <= h_eff_next;
    a_sat  <= a_sat_next;
    a_full <= a_sat_next[AMOUNT_W-1];
    a_sq   <= 32'(a_sat_next[15:0]) * 32'(a_sat_next[15:0]);
    w_sq   <= (2*WW)'(w_eff_next) * (2*WW)'(w_eff_next);
    h_sq   <= (2*HW)'(h_eff_next) * (2*HW)'(h_eff_next);
    w_inv  <= (WW+17)'(w_eff_next) * (WW+17)'(inv_next);
    h_inv  <= (HW+17)'(h_eff_next) * (HW+17)'(inv_next);
  end

  // ---- stage 2: borders (rounded half up), center, radius squared
  logic [WW+17:0] xb_sum;
  logic [HW+17:0] yb_sum;
  logic [SZ-1:0]  rsq;
  logic [31:0]    a_sq2;
  logic           a_full2;
  logic [WW-1:0]  w_eff2;
  logic [HW-1:0]  h_eff2;

  assign xb_sum = (WW+18)'(w_inv) + (WW+18)'(Q16_ONE);
  assign yb_sum = (HW+18)'(h_inv) + (HW+18)'(Q16_ONE);

  always_ff @(posedge clk) begin
    xb      <= xb_sum[WW+16:17];
    yb      <= yb_sum[HW+16:17];
    rsq     <= SZ'(w_sq) + SZ'(h_sq);
    w_last  <= CW'(w_eff - WW'(1));
    h_last  <= RC'(h_eff - HW'(1));
    cx      <= CW'(w_eff >> 1);
    cy      <= RC'(h_eff >> 1);
    a_sq2   <= a_sq;
    a_full2 <= a_full;
    w_eff2  <= w_eff;
    h_eff2  <= h_eff;
  end

  // ---- stage 3: far borders and a^2 * (W^2 + H^2)
  always_ff @(posedge clk) begin
    x_hi <= w_eff2 - xb;
    y_hi <= h_eff2 - yb;
    if (a_full2) begin
      rhs <= RHS_W'(rsq) << 32;
    end else begin
      rhs <= RHS_W'(a_sq2) * RHS_W'(rsq);
    end
  end

endmodule

`default_nettype wire

// ===== sv/vtwm_position.sv =====
// ----------------------------------------------------------------------------
// vtwm_position
// Input register: raster counters, center offsets and the dissolve LCG,
// captured with the pixel pair on each accepted transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module vtwm_position
  import vtwm_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int RC = $clog2(MAX_HEIGHT)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire pixel_in_t         in_data,
  input  wire logic              hold,
  input  wire logic [SEED_W-1:0] seed,
  input  wire logic [CW-1:0]     w_last,
  input  wire logic [RC-1:0]     h_last,
  input  wire logic [CW-1:0]     cx,
  input  wire logic [RC-1:0]     cy,
  input  wire logic              s1_take,
  output logic                   s1_valid,
  output pixel_in_t              s1_pixels,
  output logic [CW-1:0]          s1_col,
  output logic [RC-1:0]          s1_row,
  output logic [CW-1:0]          s1_adx,
  output logic [RC-1:0]          s1_ady,
  output logic [SEED_W-1:0]      s1_rand,
  output logic                   s1_frame_end
);

  logic [CW-1:0]     col;
  logic [RC-1:0]     row;
  logic [SEED_W-1:0] random_state;
  logic              accept;
  logic              row_end;
  logic              frm_end;
  logic [SEED_W-1:0] rand_next;

  assign in_stall = hold || (s1_valid && !s1_take);
  assign accept   = in_valid && !in_stall;

  assign row_end = (col >= w_last);
  assign frm_end = row_end && (row >= h_last);

  // multiplier 1073741789 = 2^30 - 35
  assign rand_next = (random_state << 30) - (random_state << 5)
                   - (random_state << 1) - random_state + LCG_ADD;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      col          <= '0;
      row          <= '0;
      random_state <= SEED_RESET;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_take) begin
        s1_valid <= 1'b0;
      end
      if (accept) begin
        if (frm_end) begin
          col          <= '0;
          row          <= '0;
          random_state <= seed;
        end else if (row_end) begin
          col          <= '0;
          row          <= row + RC'(1);
          random_state <= rand_next;
        end else begin
          col          <= col + CW'(1);
          random_state <= rand_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixels    <= in_data;
      s1_col       <= col;
      s1_row       <= row;
      s1_adx       <= (col >= cx) ? (col - cx) : (cx - col);
      s1_ady       <= (row >= cy) ? (row - cy) : (cy - row);
      s1_rand      <= rand_next;
      s1_frame_end <= frm_end;
    end
  end

endmodule

`default_nettype wire

// ===== sv/vtwm_decide.sv =====
// ----------------------------------------------------------------------------
// vtwm_decide
// Per-pixel mode decision (box, circle, dissolve) and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module vtwm_decide
  import vtwm_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  parameter int PIXEL_BITS = 32,
  localparam int CW  = $clog2(MAX_WIDTH),
  localparam int RC  = $clog2(MAX_HEIGHT),
  localparam int WW  = $clog2(MAX_WIDTH + 1),
  localparam int HW  = $clog2(MAX_HEIGHT + 1),
  localparam int SW  = (WW > HW) ? WW : HW,
  localparam int SZ  = 2 * SW + 1,
  localparam int RHS_W = 32 + SZ
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [MODE_W-1:0]   mode,
  input  wire logic [AMOUNT_W-1:0] a_sat,
  input  wire logic [WW-1:0]       xb,
  input  wire logic [HW-1:0]       yb,
  input  wire logic [WW-1:0]       x_hi,
  input  wire logic [HW-1:0]       y_hi,
  input  wire logic [RHS_W-1:0]    rhs,
  input  wire logic                s1_valid,
  input  wire pixel_in_t           s1_pixels,
  input  wire logic [CW-1:0]       s1_col,
  input  wire logic [RC-1:0]       s1_row,
  input  wire logic [CW-1:0]       s1_adx,
  input  wire logic [RC-1:0]       s1_ady,
  input  wire logic [SEED_W-1:0]   s1_rand,
  input  wire logic                s1_frame_end,
  output logic                     s1_take,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output pixel_out_t               out_data
);

  localparam int DW    = (CW > RC) ? CW : RC;
  localparam int D2W   = 2 * DW + 1;
  localparam int LHS_W = D2W + CIRCLE_SHIFT;
  localparam int CMP_W = (LHS_W > RHS_W) ? LHS_W : RHS_W;

  logic [2*CW-1:0]    sq_x;
  logic [2*RC-1:0]    sq_y;
  logic [D2W-1:0]     d2;
  logic               in_rect;
  logic               in_circle;
  logic               in_dissolve;
  logic               second;
  logic [PIXEL_W-1:0] chosen;
  logic [PIXEL_W-1:0] masked;

  assign sq_x = (2*CW)'(s1_adx) * (2*CW)'(s1_adx);
  assign sq_y = (2*RC)'(s1_ady) * (2*RC)'(s1_ady);
  assign d2   = D2W'(sq_x) + D2W'(sq_y);

  assign in_rect = (WW'(s1_col) >= xb) && (WW'(s1_col) < x_hi)
                && (HW'(s1_row) >= yb) && (HW'(s1_row) < y_hi);
  assign in_circle   = ((CMP_W'(d2) << CIRCLE_SHIFT) <= CMP_W'(rhs));
  assign in_dissolve = ({1'b0, s1_rand[31:16]} < a_sat);

  always_comb begin
    case (mode)
      MODE_RECT:     second = in_rect;
      MODE_CIRCLE:   second = in_circle;
      MODE_DISSOLVE: second = in_dissolve;
      default:       second = 1'b0;
    endcase
    chosen = second ? s1_pixels.second_pixel : s1_pixels.first_pixel;
    for (int i = 0; i < PIXEL_W; i++) begin
      masked[i] = (i < PIXEL_BITS) ? chosen[i] : 1'b0;
    end
  end

  assign s1_take = s1_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      out_data.mixed_pixel <= masked;
      out_data.took_second <= second;
      out_data.frame_end   <= s1_frame_end;
    end
  end

endmodule

`default_nettype wire

// ===== sv/video_transition_wipe_mixer.sv =====
// ----------------------------------------------------------------------------
// video_transition_wipe_mixer
// Two-frame transition mixer: rectangle iris, circle iris or random dissolve.
// ----------------------------------------------------------------------------
// Usage:
//   Pixel pairs (first_pixel, second_pixel) enter on in_valid/in_stall in
//   raster order; one result per pair leaves on out_valid/out_stall with the
//   chosen pixel, a took_second flag and frame_end on the last pixel.
//   A transaction completes on a clock edge where valid is high and stall low.
//   Each pair passes the input register, then the result register; throughput
//   is one pixel per clock while out_stall is low and no write is settling.
//   A full output stalled by the receiver still lets one more pixel into the
//   input register; further input is stalled until the result is taken.
//   Configuration (mode, amount, width, height, seed) is written on
//   cfg_write/cfg_index/cfg_data while the stream is idle. The input is
//   stalled in the write cycle and afterwards while the geometry
//   pipeline recomputes borders and the circle radius term.
//   Synchronous reset loads the default registers, zeroes the raster
//   position, reloads the random generator from the seed and stalls input
//   after release while the geometry pipeline settles. Seed changes apply
//   at the next frame start.
// ----------------------------------------------------------------------------
`default_nettype none

module video_transition_wipe_mixer
  import vtwm_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  parameter int PIXEL_BITS = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire pixel_in_t              in_data,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output pixel_out_t                  out_data
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RC  = $clog2(MAX_HEIGHT);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int SW  = (WW > HW) ? WW : HW;
  localparam int SZ  = 2 * SW + 1;
  localparam int RHS_W = 32 + SZ;

  logic                busy;
  logic [MODE_W-1:0]   mode;
  logic [SEED_W-1:0]   seed;
  logic [AMOUNT_W-1:0] a_sat;
  logic [CW-1:0]       w_last;
  logic [RC-1:0]       h_last;
  logic [CW-1:0]       cx;
  logic [RC-1:0]       cy;
  logic [WW-1:0]       xb;
  logic [HW-1:0]       yb;
  logic [WW-1:0]       x_hi;
  logic [HW-1:0]       y_hi;
  logic [RHS_W-1:0]    rhs;
  logic                hold;

  logic                s1_take;
  logic                s1_valid;
  pixel_in_t           s1_pixels;
  logic [CW-1:0]       s1_col;
  logic [RC-1:0]       s1_row;
  logic [CW-1:0]       s1_adx;
  logic [RC-1:0]       s1_ady;
  logic [SEED_W-1:0]   s1_rand;
  logic                s1_frame_end;

  vtwm_setup #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_setup (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .busy      (busy),
    .mode      (mode),
    .seed      (seed),
    .a_sat     (a_sat),
    .w_last    (w_last),
    .h_last    (h_last),
    .cx        (cx),
    .cy        (cy),
    .xb        (xb),
    .yb        (yb),
    .x_hi      (x_hi),
    .y_hi      (y_hi),
    .rhs       (rhs)
  );

  // no pixels enter during reset, a register write or geometry update
  assign hold = rst || cfg_write || busy;

  vtwm_position #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_position (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .hold         (hold),
    .seed         (seed),
    .w_last       (w_last),
    .h_last       (h_last),
    .cx           (cx),
    .cy           (cy),
    .s1_take      (s1_take),
    .s1_valid     (s1_valid),
    .s1_pixels    (s1_pixels),
    .s1_col       (s1_col),
    .s1_row       (s1_row),
    .s1_adx       (s1_adx),
    .s1_ady       (s1_ady),
    .s1_rand      (s1_rand),
    .s1_frame_end (s1_frame_end)
  );

  vtwm_decide #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_decide (
    .clk          (clk),
    .rst          (rst),
    .mode         (mode),
    .a_sat        (a_sat),
    .xb           (xb),
    .yb           (yb),
    .x_hi         (x_hi),
    .y_hi         (y_hi),
    .rhs          (rhs),
    .s1_valid     (s1_valid),
    .s1_pixels    (s1_pixels),
    .s1_col       (s1_col),
    .s1_row       (s1_row),
    .s1_adx       (s1_adx),
    .s1_ady       (s1_ady),
    .s1_rand      (s1_rand),
    .s1_frame_end (s1_frame_end),
    .s1_take      (s1_take),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data)
  );

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the wipe / iris / dissolve mixer: a driver feeds
// pixel pairs from a queue, a bit-exact predictor computes the expected
// selection per pixel, and a monitor compares every output transaction.
// ----------------------------------------------------------------------------

module testbench;
  import vtwm_pkg::*;

  localparam int FRAME_MAX_W = 4096;
  localparam int FRAME_MAX_H = 4096;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam logic [31:0] LCG_MULT = 32'd1073741789;
  localparam int HOLD_OFF_CYCLES = 60;
  localparam int WATCHDOG_LIMIT = 2000;

  logic clk;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  pixel_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  pixel_out_t out_data;

  video_transition_wipe_mixer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // predictor copy of the registers and raster state
  logic [MODE_W-1:0]     mode_reg;
  logic [AMOUNT_W-1:0]   amount_reg;
  logic [SIZE_CFG_W-1:0] width_reg;
  logic [SIZE_CFG_W-1:0] height_reg;
  logic [SEED_W-1:0]     seed_reg;
  int unsigned col_pos;
  int unsigned row_pos;
  logic [31:0] lcg_state;

  pixel_in_t  pair_queue[$];
  pixel_out_t mix_expected[$];
  int pairs_queued = 0;
  int pairs_taken = 0;
  int mismatches = 0;
  int send_idle_pct = 37;
  int recv_idle_pct = 60;
  bit hold_off_armed = 1'b0;
  bit hold_off_done = 1'b0;
  int hold_off_left = 0;
  int stuck_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned clamp_size(input int unsigned v, input int unsigned max_v);
    if (v == 0) return 1;
    if (v > max_v) return max_v;
    return v;
  endfunction

  task automatic predict_mix(input pixel_in_t px);
    int unsigned w, h, a;
    logic [31:0] nxt;
    longint unsigned inv, xb, yb, lhs, rhs;
    longint dx, dy;
    bit second, row_end, frm_end;
    pixel_out_t res;
    w = clamp_size(width_reg, FRAME_MAX_W);
    h = clamp_size(height_reg, FRAME_MAX_H);
    a = (amount_reg > Q16_ONE) ? Q16_ONE : amount_reg;
    nxt = lcg_state * LCG_MULT + LCG_ADD;
    case (mode_reg)
      MODE_RECT: begin
        inv = longint'(Q16_ONE) - a;
        xb = (longint'(w) * inv + longint'(Q16_ONE)) >> 17;
        yb = (longint'(h) * inv + longint'(Q16_ONE)) >> 17;
        second = col_pos >= xb && col_pos < w - xb && row_pos >= yb && row_pos < h - yb;
      end
      MODE_CIRCLE: begin
        dx = longint'(col_pos) - longint'(w >> 1);
        dy = longint'(row_pos) - longint'(h >> 1);
        lhs = longint'(dx * dx + dy * dy) << CIRCLE_SHIFT;
        rhs = longint'(a) * longint'(a) * (longint'(w) * w + longint'(h) * h);
        second = lhs <= rhs;
      end
      MODE_DISSOLVE: second = (nxt >> 16) < a;
      default: second = 1'b0;
    endcase
    lcg_state = nxt;
    row_end = col_pos >= w - 1;
    frm_end = row_end && row_pos >= h - 1;
    res.mixed_pixel = second ? px.second_pixel : px.first_pixel;
    res.took_second = second;
    res.frame_end = frm_end;
    mix_expected.push_back(res);
    if (frm_end) begin
      col_pos = 0;
      row_pos = 0;
      lcg_state = seed_reg;
    end else if (row_end) begin
      col_pos = 0;
      row_pos = row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  // driver: a stalled transaction is held, otherwise the next pair may go out
  always @(posedge clk) begin : pair_drive
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_mix(in_data);
        pairs_taken++;
      end
      if (!(in_valid && in_stall)) begin
        if (pair_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_data <= pair_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    pixel_out_t want;
    logic stall_next;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (mix_expected.size() == 0) begin
          $error("unexpected transaction: mixed_pixel %h", out_data.mixed_pixel);
          mismatches++;
        end else begin
          want = mix_expected.pop_front();
          if (out_data.mixed_pixel !== want.mixed_pixel) begin
            $error("mixed_pixel: expected %h, got %h", want.mixed_pixel, out_data.mixed_pixel);
            mismatches++;
          end
          if (out_data.took_second !== want.took_second) begin
            $error("took_second: expected %b, got %b", want.took_second, out_data.took_second);
            mismatches++;
          end
          if (out_data.frame_end !== want.frame_end) begin
            $error("frame_end: expected %b, got %b", want.frame_end, out_data.frame_end);
            mismatches++;
          end
        end
      end
      // one long hold-off so the block backs up into its input
      if (hold_off_left != 0) begin
        hold_off_left <= hold_off_left - 1;
        stall_next = 1'b1;
      end else if (hold_off_armed && !hold_off_done && out_valid) begin
        hold_off_left <= HOLD_OFF_CYCLES;
        hold_off_done <= 1'b1;
        stall_next = 1'b1;
      end else begin
        stall_next = $urandom_range(0, 99) < recv_idle_pct;
      end
      out_stall <= stall_next;
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_MODE:   mode_reg = val[MODE_W-1:0];
      REG_AMOUNT: amount_reg = val[AMOUNT_W-1:0];
      REG_WIDTH:  width_reg = val[SIZE_CFG_W-1:0];
      REG_HEIGHT: height_reg = val[SIZE_CFG_W-1:0];
      REG_SEED:   seed_reg = val;
      default: ;
    endcase
  endtask

  task automatic end_writes;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic wait_idle;
    do @(posedge clk); while (pairs_taken != pairs_queued || mix_expected.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic queue_pair(input logic [PIXEL_W-1:0] f, input logic [PIXEL_W-1:0] s);
    pixel_in_t p;
    p.first_pixel = f;
    p.second_pixel = s;
    pair_queue.push_back(p);
    pairs_queued++;
  endtask

  // alternate all-zero / all-one pixels with random ones
  task automatic directed_pairs(input int n);
    for (int k = 0; k < n; k++) begin
      case (k % 3)
        0: queue_pair('0, '1);
        1: queue_pair('1, '0);
        default: queue_pair($urandom(), $urandom());
      endcase
    end
  endtask

  // junk in the bits above the register width must be ignored
  function automatic logic [CFG_DATA_W-1:0] cfg_word(input int unsigned v, input int bits);
    logic [CFG_DATA_W-1:0] mask;
    mask = (32'd1 << bits) - 1;
    if ($urandom_range(0, 3) != 0) return v & mask;
    return ($urandom() & ~mask) | (v & mask);
  endfunction

  function automatic int unsigned pick_amount;
    case ($urandom_range(0, 5))
      0: return 0;
      1: return Q16_ONE;
      2: return $urandom_range(65537, 131071);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic int unsigned pick_size;
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 4096;
      2: return $urandom_range(4097, 8191);
      3: return $urandom_range(13, 300);
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  initial begin : stimulus
    int pick;
    mode_reg = MODE_RECT;
    amount_reg = '0;
    width_reg = WIDTH_RESET;
    height_reg = HEIGHT_RESET;
    seed_reg = SEED_RESET;
    col_pos = 0;
    row_pos = 0;
    lcg_state = SEED_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset values: rectangle at zero amount on a 640x480 frame
    wait_idle();
    directed_pairs(2);
    // dissolve from the reset seed
    wait_idle();
    write_reg(REG_MODE, MODE_DISSOLVE);
    write_reg(REG_AMOUNT, 17'h08000);
    end_writes();
    directed_pairs(3);
    // zero sizes act as 1x1, every pixel ends a frame
    wait_idle();
    write_reg(REG_MODE, MODE_RECT);
    write_reg(REG_WIDTH, 0);
    write_reg(REG_HEIGHT, 0);
    end_writes();
    directed_pairs(2);
    // 3x3 circle at zero amount: only the center is second
    wait_idle();
    write_reg(REG_MODE, MODE_CIRCLE);
    write_reg(REG_AMOUNT, 0);
    write_reg(REG_WIDTH, 3);
    write_reg(REG_HEIGHT, 3);
    end_writes();
    directed_pairs(9);
    wait_idle();
    write_reg(REG_MODE, MODE_UNUSED);
    write_reg(REG_AMOUNT, Q16_ONE);
    end_writes();
    directed_pairs(2);
    // saturated amount, seed written mid-frame
    wait_idle();
    write_reg(REG_MODE, MODE_DISSOLVE);
    write_reg(REG_AMOUNT, 17'h1FFFF);
    write_reg(REG_SEED, 0);
    end_writes();
    directed_pairs(3);
    // oversize frame saturates, full amount opens the whole rectangle
    wait_idle();
    write_reg(REG_MODE, MODE_RECT);
    write_reg(REG_AMOUNT, Q16_ONE);
    write_reg(REG_WIDTH, 13'h1FFF);
    write_reg(REG_HEIGHT, 13'h1FFF);
    write_reg(REG_SEED, 32'hFFFFFFFF);
    end_writes();
    directed_pairs(2);
    // shrink mid-frame: counters already past the new last position
    wait_idle();
    write_reg(REG_WIDTH, 2);
    write_reg(REG_HEIGHT, 2);
    end_writes();
    directed_pairs(2);

    for (int ph = 0; ph < 12; ph++) begin
      wait_idle();
      send_idle_pct = (ph < 4) ? 37 : (ph < 8) ? 60 : 0;
      recv_idle_pct = (ph < 4) ? 60 : (ph < 8) ? 37 : 0;
      pick = $urandom_range(0, 9);
      write_reg(REG_MODE, cfg_word((pick == 9) ? MODE_UNUSED : pick % 3, MODE_W));
      write_reg(REG_AMOUNT, cfg_word(pick_amount(), AMOUNT_W));
      if ($urandom_range(0, 2) != 0) write_reg(REG_WIDTH, cfg_word(pick_size(), SIZE_CFG_W));
      if ($urandom_range(0, 2) != 0) write_reg(REG_HEIGHT, cfg_word(pick_size(), SIZE_CFG_W));
      if ($urandom_range(0, 1) != 0) write_reg(REG_SEED, $urandom());
      end_writes();
      if (ph == 8) hold_off_armed = 1'b1;
      repeat (78) queue_pair($urandom(), $urandom());
    end

    wait_idle();
    repeat (6) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/vtwm_pkg.sv
sv/vtwm_setup.sv
sv/vtwm_position.sv
sv/vtwm_decide.sv
sv/video_transition_wipe_mixer.sv
verif/testbench.sv
